FILE: rtl/core/csta_pkg.sv
`default_nettype none
package csta_pkg;

   localparam int SAMPLE_W = 16;
   localparam int UPT_W    = 10;
   localparam int PROD_W   = 26;
   localparam int QUO_W    = 17;
   localparam int PART_W   = 10;
   localparam int SEC_W    = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // register select is paddr[2]
   localparam logic CSR_IDX_US_PER_TICK = 1'b0;
   localparam logic CSR_IDX_RELOAD      = 1'b1;

   localparam logic [UPT_W-1:0]    US_PER_TICK_RST   = 10'd1;
   localparam logic [SAMPLE_W-1:0] RELOAD_PERIOD_RST = 16'hFFFF;

   localparam logic [PART_W-1:0] PART_MOD = 10'd1000;

   // floor(2^30 / 1000); estimate is exact or one low for inputs below 2^26
   localparam int                DIV_SHIFT = 30;
   localparam int                RECIP_W   = 21;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1073741;

   typedef struct packed {
      logic                func;
      logic [SAMPLE_W-1:0] counter_sample;
   } csta_req_type;

   typedef struct packed {
      logic [SEC_W-1:0]  seconds_now;
      logic [PART_W-1:0] millis_now;
      logic [PART_W-1:0] micros_now;
   } csta_rsp_type;

   typedef struct packed {
      logic                push;
      logic [SAMPLE_W-1:0] delta;
   } csta_delta_type;

endpackage
`default_nettype wire

FILE: rtl/core/csta_front.sv
`default_nettype none
module csta_front import csta_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   input  wire csta_req_type        req_data,
   input  wire logic                q_full,
   input  wire logic [SAMPLE_W-1:0] reload_period,
   output      csta_delta_type      dq
);

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                accept;
   logic [SAMPLE_W-1:0] add_term;

   always_comb begin
      accept   = req_push && !q_full;
      add_term = req_data.func ? reload_period : '0;
      prev_in  = accept ? req_data.counter_sample : prev_ff;
      dq.push  = accept;
      // tick delta wraps at 16 bits
      dq.delta = req_data.counter_sample - prev_ff + add_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/csta_fifo.sv
`default_nettype none
module csta_fifo import csta_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire csta_delta_type      dq,
   input  wire logic                pop,
   output      logic                full,
   output      logic                empty,
   output      logic [SAMPLE_W-1:0] rdata
);

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   logic [SAMPLE_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_W:0]      cnt_ff, cnt_in;
   logic                do_pop;

   always_comb begin
      full    = (cnt_ff == (PTR_W+1)'(DEPTH));
      empty   = (cnt_ff == '0);
      rdata   = slot_ff[rptr_ff];
      do_pop  = pop && !empty;
      wptr_in = dq.push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (PTR_W+1)'(dq.push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (dq.push) begin
         slot_ff[wptr_ff] <= dq.delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/csta_div1k.sv
`default_nettype none
module csta_div1k import csta_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [PROD_W-1:0] x,
   output      logic [QUO_W-1:0]  q,
   output      logic [PART_W-1:0] r
);

   logic [PROD_W+RECIP_W-1:0] est_full;
   logic [QUO_W-1:0]          est_ff, est_in;
   logic [PROD_W-1:0]         x_ff;
   logic [QUO_W-1:0]          q_ff, q_in;
   logic [PART_W-1:0]         r_ff, r_in;
   logic [PROD_W-1:0]         back_mul;
   logic [PART_W:0]           rem;
   logic                      fix;

   always_comb begin
      est_full = {{RECIP_W{1'b0}}, x} * {{PROD_W{1'b0}}, DIV_RECIP};
      est_in   = est_full[DIV_SHIFT +: QUO_W];
      back_mul = PROD_W'(est_ff) * PROD_W'(PART_MOD);
      // true remainder is below 2000, so 11 bits carry it exactly
      rem      = x_ff[PART_W:0] - back_mul[PART_W:0];
      fix      = (rem >= (PART_W+1)'(PART_MOD));
      q_in     = est_ff + QUO_W'(fix);
      r_in     = fix ? PART_W'(rem - (PART_W+1)'(PART_MOD)) : rem[PART_W-1:0];
      q        = q_ff;
      r        = r_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         est_ff <= est_in;
         x_ff   <= x;
         q_ff   <= q_in;
         r_ff   <= r_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/csta_back.sv
`default_nettype none
module csta_back import csta_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire logic [SAMPLE_W-1:0] q_data,
   output      logic                q_pop,
   input  wire logic [UPT_W-1:0]    us_per_tick,
   input  wire logic                rsp_pop,
   output      logic                rsp_empty,
   output      csta_rsp_type        rsp_data
);

   logic                adv;
   logic [4:0]          vld_ff, vld_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [QUO_W-1:0]    qa;
   logic [PART_W-1:0]   ra;
   logic [QUO_W-1:0]    qb;
   logic [PART_W-1:0]   rb;
   logic [PART_W-1:0]   ra_d1_ff, ra_d2_ff;
   logic                out_vld_ff, out_vld_in;
   logic [PART_W-1:0]   micro_ff, micro_in, milli_ff, milli_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;
   logic [PART_W:0]     us_sum, ms_sum;
   logic                c_us, c_ms;

   // whole pipeline moves in lockstep; it holds while a result waits
   always_comb begin
      adv    = !out_vld_ff || rsp_pop;
      q_pop  = adv && !q_empty;
      vld_in = {vld_ff[3:0], !q_empty};
      prod_in = {{(PROD_W-SAMPLE_W){1'b0}}, q_data} *
                {{(PROD_W-UPT_W){1'b0}}, us_per_tick};
   end

   // product split into ms and us, then ms split into s and ms
   csta_div1k u_div_us (
      .clock (clock),
      .en    (adv),
      .x     (prod_ff),
      .q     (qa),
      .r     (ra)
   );

   csta_div1k u_div_ms (
      .clock (clock),
      .en    (adv),
      .x     ({{(PROD_W-QUO_W){1'b0}}, qa}),
      .q     (qb),
      .r     (rb)
   );

   always_comb begin
      us_sum   = {1'b0, micro_ff} + {1'b0, ra_d2_ff};
      c_us     = (us_sum >= (PART_W+1)'(PART_MOD));
      ms_sum   = {1'b0, milli_ff} + {1'b0, rb} + (PART_W+1)'(c_us);
      c_ms     = (ms_sum >= (PART_W+1)'(PART_MOD));
      micro_in = c_us ? PART_W'(us_sum - (PART_W+1)'(PART_MOD)) : us_sum[PART_W-1:0];
      milli_in = c_ms ? PART_W'(ms_sum - (PART_W+1)'(PART_MOD)) : ms_sum[PART_W-1:0];
      sec_in   = sec_ff + SEC_W'(qb) + SEC_W'(c_ms);
      out_vld_in = adv ? vld_ff[4] : out_vld_ff;

      rsp_empty            = !out_vld_ff;
      rsp_data.seconds_now = sec_ff;
      rsp_data.millis_now  = milli_ff;
      rsp_data.micros_now  = micro_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         ra_d1_ff <= ra;
         ra_d2_ff <= ra_d1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
         micro_ff   <= '0;
         milli_ff   <= '0;
         sec_ff     <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (adv) begin
            vld_ff <= vld_in;
            if (vld_ff[4]) begin
               micro_ff <= micro_in;
               milli_ff <= milli_in;
               sec_ff   <= sec_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/counter_sample_time_accumulator.sv
// A result reaches the rsp_ ports once its item has passed the delta queue
// and then the multiply/divide-by-1000 pipeline.
// Throughput: 1 item per cycle; the back pipeline holds while a result waits.
// Reset: synchronous; time and last sample clear to zero, us_per_tick to 1,
// reload_period to 65535; no clearing pass.
`default_nettype none
module counter_sample_time_accumulator import csta_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire csta_req_type      req_data,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      csta_rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output      logic [CSR_DW-1:0] csr_prdata,
   output      logic              csr_pready
);

   logic [UPT_W-1:0]    upt_ff, upt_in;
   logic [SAMPLE_W-1:0] reload_ff, reload_in;
   logic                csr_wr;
   csta_delta_type      dq;
   logic                q_pop, q_empty;
   logic [SAMPLE_W-1:0] q_data;

   // low address bits are the byte offset
   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite;
      upt_in     = upt_ff;
      reload_in  = reload_ff;
      case (csr_paddr[2])
         CSR_IDX_US_PER_TICK: begin
            csr_prdata = {{(CSR_DW-UPT_W){1'b0}}, upt_ff};
            if (csr_wr) upt_in = csr_pwdata[UPT_W-1:0];
         end
         default: begin
            csr_prdata = {{(CSR_DW-SAMPLE_W){1'b0}}, reload_ff};
            if (csr_wr) reload_in = csr_pwdata[SAMPLE_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upt_ff    <= US_PER_TICK_RST;
         reload_ff <= RELOAD_PERIOD_RST;
      end else begin
         upt_ff    <= upt_in;
         reload_ff <= reload_in;
      end
   end

   csta_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .q_full        (req_full),
      .reload_period (reload_ff),
      .dq            (dq)
   );

   csta_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .dq    (dq),
      .pop   (q_pop),
      .full  (req_full),
      .empty (q_empty),
      .rdata (q_data)
   );

   csta_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .us_per_tick (upt_ff),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
